// ===== hdl/pgsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgsc_pkg
// Shared types, widths and constants of the platoon gap and speed controller.
// ----------------------------------------------------------------------------
package pgsc_pkg;

  localparam int unsigned SpeedW   = 14;
  localparam int unsigned TimeGapW = 11;
  localparam int unsigned TicksW   = 7;
  localparam int unsigned IdW      = 16;
  localparam int unsigned DistW    = 17;
  localparam int unsigned LenW     = 13;
  localparam int unsigned AccelInW = 13;
  localparam int unsigned AccelW   = 16;
  localparam int unsigned GapW     = 18;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned QuotW    = 15;
  localparam int unsigned SpaceW   = 26;
  localparam int unsigned RateW    = 26;

  typedef enum logic [CfgIdxW-1:0] {
    CfgManualSpeed  = 3'd0,
    CfgPlatoonSpeed = 3'd1,
    CfgPlatoonGap   = 3'd2,
    CfgDriverGap    = 3'd3,
    CfgTicks        = 3'd4
  } cfg_index_e;

  localparam logic [SpeedW-1:0]   ManualSpeedRst  = 14'd7439;
  localparam logic [SpeedW-1:0]   PlatoonSpeedRst = 14'd8010;
  localparam logic [TimeGapW-1:0] PlatoonGapRst   = 11'd154;
  localparam logic [TimeGapW-1:0] DriverGapRst    = 11'd384;
  localparam logic [TicksW-1:0]   TicksRst        = 7'd10;

  localparam logic [1:0] StatusOff      = 2'd0;
  localparam logic [1:0] StatusLeader   = 2'd1;
  localparam logic [1:0] StatusFollower = 2'd2;
  localparam logic [1:0] StatusMember   = 2'd3;
  localparam logic [2:0] LeaderKnownMax = 3'd3;

  localparam logic [1:0] ColourRed    = 2'd0;
  localparam logic [1:0] ColourYellow = 2'd1;
  localparam logic [1:0] ColourBlue   = 2'd2;

  localparam logic ModeSpeed = 1'b0;
  localparam logic ModeGap   = 1'b1;

  localparam logic signed [GapW-1:0] GapFar  = 18'sd30720;
  localparam logic signed [GapW-1:0] GapNear = 18'sd25600;
  localparam logic [SpeedW-1:0]      LowSpeed = 14'd2859;
  localparam logic [SpaceW-1:0]      SlowMargin = 26'd196608;
  localparam logic [CountW-1:0]      CountMax = 16'hFFFF;

  // floor((5 - 4*err) / 10) = floor((DivBias - 4*err) / 10) - DivOffset,
  // the divide by ten done as a multiply by QuotMul and a shift
  localparam logic [17:0] DivBias  = 18'd65545;
  localparam logic [15:0] QuotMul  = 16'd52429;
  localparam int unsigned QuotShift = 19;
  localparam logic signed [16:0] DivOffset = 17'sd6554;
  localparam logic signed [16:0] AccelCap  = 17'sd512;

  typedef struct packed {
    logic [SpeedW-1:0]   manual_speed;
    logic [SpeedW-1:0]   platoon_speed;
    logic [TimeGapW-1:0] platoon_gap;
    logic [TimeGapW-1:0] driver_gap;
    logic [TicksW-1:0]   ticks;
  } cfg_t;

  typedef struct packed {
    logic                       gap_mode;
    logic                       platoon_role;
    logic signed [AccelInW-1:0] driver_accel;
    logic [QuotW-1:0]           speed_quot;
    logic [SpaceW-1:0]          spacing;
    logic signed [RateW-1:0]    rate;
    logic signed [GapW-1:0]     gap;
    logic                       gap_valid;
    logic [1:0]                 colour;
    logic [CountW-1:0]          follow;
  } mid_t;

endpackage

// ===== hdl/pgsc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgsc_if
// Channel interfaces: tick input, command output and register write.
// ----------------------------------------------------------------------------
interface pgsc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 has_leader;
  logic [pgsc_pkg::IdW-1:0]             lead_vid;
  logic [pgsc_pkg::DistW-1:0]           lead_distance;
  logic [pgsc_pkg::LenW-1:0]            lead_length;
  logic [pgsc_pkg::SpeedW-1:0]          own_speed;
  logic [1:0]                           own_status;
  logic [2:0]                           leader_status;
  logic signed [pgsc_pkg::AccelInW-1:0] driver_accel;

  modport source (
    output valid, has_leader, lead_vid, lead_distance, lead_length, own_speed,
           own_status, leader_status, driver_accel,
    input  ready
  );
  modport sink (
    input  valid, has_leader, lead_vid, lead_distance, lead_length, own_speed,
           own_status, leader_status, driver_accel,
    output ready
  );
endinterface

interface pgsc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pgsc_pkg::AccelW-1:0] accel_command;
  logic                               gap_mode;
  logic [1:0]                         status_colour;
  logic [pgsc_pkg::CountW-1:0]        follow_ticks;
  logic signed [pgsc_pkg::GapW-1:0]   bumper_gap;
  logic                               gap_valid;

  modport source (
    output valid, accel_command, gap_mode, status_colour, follow_ticks,
           bumper_gap, gap_valid,
    input  ready
  );
  modport sink (
    input  valid, accel_command, gap_mode, status_colour, follow_ticks,
           bumper_gap, gap_valid,
    output ready
  );
endinterface

interface pgsc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pgsc_pkg::CfgIdxW-1:0]  index;
  logic [pgsc_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/pgsc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgsc_cfg_regs
// Configuration register file, written one word at a time.
// ----------------------------------------------------------------------------
module pgsc_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  pgsc_cfg_if.sink         cfg_i,
  output pgsc_pkg::cfg_t   cfg_o
);

  pgsc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        pgsc_pkg::CfgManualSpeed:  cfg_d.manual_speed  = cfg_i.data;
        pgsc_pkg::CfgPlatoonSpeed: cfg_d.platoon_speed = cfg_i.data;
        pgsc_pkg::CfgPlatoonGap:   cfg_d.platoon_gap   = cfg_i.data[pgsc_pkg::TimeGapW-1:0];
        pgsc_pkg::CfgDriverGap:    cfg_d.driver_gap    = cfg_i.data[pgsc_pkg::TimeGapW-1:0];
        pgsc_pkg::CfgTicks:        cfg_d.ticks         = cfg_i.data[pgsc_pkg::TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.manual_speed  <= pgsc_pkg::ManualSpeedRst;
      cfg_q.platoon_speed <= pgsc_pkg::PlatoonSpeedRst;
      cfg_q.platoon_gap   <= pgsc_pkg::PlatoonGapRst;
      cfg_q.driver_gap    <= pgsc_pkg::DriverGapRst;
      cfg_q.ticks         <= pgsc_pkg::TicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/pgsc_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgsc_track
// Input register, gap history, follow counter and mode hysteresis, plus the
// products of the command path, registered into the middle stage.
// ----------------------------------------------------------------------------
module pgsc_track (
  input  logic            clk_i,
  input  logic            rst_ni,
  pgsc_in_if.sink         in_i,
  input  pgsc_pkg::cfg_t  cfg_i,
  output logic            mid_valid_o,
  input  logic            mid_ready_i,
  output pgsc_pkg::mid_t  mid_o
);

  logic                                 in_valid_q;
  logic                                 has_leader_q;
  logic [pgsc_pkg::IdW-1:0]             lead_vid_q;
  logic [pgsc_pkg::DistW-1:0]           lead_distance_q;
  logic [pgsc_pkg::LenW-1:0]            lead_length_q;
  logic [pgsc_pkg::SpeedW-1:0]          own_speed_q;
  logic [1:0]                           own_status_q;
  logic [2:0]                           leader_status_q;
  logic signed [pgsc_pkg::AccelInW-1:0] driver_accel_q;

  logic signed [pgsc_pkg::GapW-1:0] gap_now_q, gap_now_d;
  logic                             gap_valid_q, gap_valid_d;
  logic                             mode_q, mode_d;
  logic [pgsc_pkg::IdW:0]           last_leader_q, last_leader_d;
  logic [pgsc_pkg::CountW-1:0]      follow_q, follow_d;

  logic                 mid_valid_q;
  pgsc_pkg::mid_t       mid_q, mid_d;

  logic                 adv;
  logic                 s1_ready;
  logic                 platoon_role;
  logic [pgsc_pkg::SpeedW-1:0]   desired;
  logic [pgsc_pkg::TimeGapW-1:0] time_gap;
  logic signed [pgsc_pkg::SpeedW:0] speed_err;
  logic signed [17:0]   speed_err4;
  logic [17:0]          div_num;
  logic [33:0]          div_prod;
  logic [pgsc_pkg::SpaceW-2:0] space_prod;
  logic signed [pgsc_pkg::GapW:0] gap_diff;
  logic signed [pgsc_pkg::RateW-1:0] rate_prod;

  assign s1_ready   = !mid_valid_q || mid_ready_i;
  assign adv        = in_valid_q && s1_ready;
  assign in_i.ready = !in_valid_q || s1_ready;

  assign platoon_role = (own_status_q == pgsc_pkg::StatusFollower) ||
                        (own_status_q == pgsc_pkg::StatusMember);
  assign desired  = platoon_role ? cfg_i.platoon_speed : cfg_i.manual_speed;
  assign time_gap = platoon_role ? cfg_i.platoon_gap : cfg_i.driver_gap;

  // gap history, follow counter, mode
  always_comb begin
    gap_now_d   = has_leader_q ?
                  $signed({1'b0, lead_distance_q} - {5'b0, lead_length_q}) : '0;
    gap_valid_d = has_leader_q;
    last_leader_d = has_leader_q ? {1'b1, lead_vid_q} : '0;
    if (has_leader_q && (last_leader_d == last_leader_q) &&
        (gap_now_d < pgsc_pkg::GapNear) &&
        (leader_status_q <= pgsc_pkg::LeaderKnownMax)) begin
      follow_d = (follow_q != pgsc_pkg::CountMax) ? follow_q + 16'd1 : follow_q;
    end else begin
      follow_d = '0;
    end
    mode_d = mode_q;
    if (!has_leader_q || (gap_now_d > pgsc_pkg::GapFar)) begin
      mode_d = pgsc_pkg::ModeSpeed;
    end
    if (gap_valid_d && gap_valid_q && (gap_now_d < pgsc_pkg::GapNear)) begin
      mode_d = pgsc_pkg::ModeGap;
    end
  end

  // products for the command path
  always_comb begin
    speed_err  = $signed({1'b0, own_speed_q}) - $signed({1'b0, desired});
    speed_err4 = {{1{speed_err[pgsc_pkg::SpeedW]}}, speed_err, 2'b00};
    div_num    = pgsc_pkg::DivBias - speed_err4;
    div_prod   = div_num * pgsc_pkg::QuotMul;
    space_prod = time_gap * own_speed_q;
    gap_diff   = {gap_now_d[pgsc_pkg::GapW-1], gap_now_d} -
                 {gap_now_q[pgsc_pkg::GapW-1], gap_now_q};
    rate_prod  = gap_diff * $signed({1'b0, cfg_i.ticks});

    mid_d.gap_mode     = mode_d;
    mid_d.platoon_role = platoon_role;
    mid_d.driver_accel = driver_accel_q;
    mid_d.speed_quot   = div_prod[pgsc_pkg::QuotShift +: pgsc_pkg::QuotW];
    mid_d.spacing      = {1'b0, space_prod} +
                         ((own_speed_q <= pgsc_pkg::LowSpeed) ? pgsc_pkg::SlowMargin : '0);
    mid_d.rate         = rate_prod;
    mid_d.gap          = gap_now_d;
    mid_d.gap_valid    = gap_valid_d;
    case (own_status_q)
      pgsc_pkg::StatusLeader:   mid_d.colour = pgsc_pkg::ColourRed;
      pgsc_pkg::StatusFollower: mid_d.colour = pgsc_pkg::ColourYellow;
      pgsc_pkg::StatusMember:   mid_d.colour = pgsc_pkg::ColourYellow;
      default:                  mid_d.colour = pgsc_pkg::ColourBlue;
    endcase
    mid_d.follow       = follow_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      mid_valid_q   <= 1'b0;
      gap_now_q     <= '0;
      gap_valid_q   <= 1'b0;
      mode_q        <= pgsc_pkg::ModeSpeed;
      last_leader_q <= '0;
      follow_q      <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (adv) begin
        mid_valid_q   <= 1'b1;
        gap_now_q     <= gap_now_d;
        gap_valid_q   <= gap_valid_d;
        mode_q        <= mode_d;
        last_leader_q <= last_leader_d;
        follow_q      <= follow_d;
      end else if (mid_ready_i) begin
        mid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      has_leader_q    <= in_i.has_leader;
      lead_vid_q      <= in_i.lead_vid;
      lead_distance_q <= in_i.lead_distance;
      lead_length_q   <= in_i.lead_length;
      own_speed_q     <= in_i.own_speed;
      own_status_q    <= in_i.own_status;
      leader_status_q <= in_i.leader_status;
      driver_accel_q  <= in_i.driver_accel;
    end
    if (adv) begin
      mid_q <= mid_d;
    end
  end

  assign mid_valid_o = mid_valid_q;
  assign mid_o       = mid_q;

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(gap_now_q) && $stable(mode_q) && $stable(follow_q))
    else $error("tracking state moved without a word");

  a_follow_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (follow_q == '0) || (follow_q == $past(follow_q) + 16'd1) ||
            (follow_q == pgsc_pkg::CountMax))
    else $error("follow counter jumped");

  a_gap_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !gap_valid_q |-> (gap_now_q == '0) && (mode_q == pgsc_pkg::ModeSpeed ||
                                           last_leader_q == '0))
    else $error("gap held without a leader");

endmodule

// ===== hdl/pgsc_command.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgsc_command
// Speed and gap command forming, saturation and the result register.
// ----------------------------------------------------------------------------
module pgsc_command (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            mid_valid_i,
  output logic            mid_ready_o,
  input  pgsc_pkg::mid_t  mid_i,
  pgsc_out_if.source      out_o
);

  logic                               out_valid_q;
  logic signed [pgsc_pkg::AccelW-1:0] accel_q, accel_d;
  logic                               mode_q;
  logic [1:0]                         colour_q;
  logic [pgsc_pkg::CountW-1:0]        follow_q;
  logic signed [pgsc_pkg::GapW-1:0]   gap_q;
  logic                               gap_valid_q;

  logic signed [16:0] asc;
  logic signed [26:0] err16;
  logic signed [26:0] err_round;
  logic signed [16:0] err_q8;
  logic signed [27:0] agap;
  logic signed [27:0] cmd;
  logic               load;

  assign mid_ready_o = !out_valid_q || out_o.ready;
  assign load        = mid_valid_i && mid_ready_o;

  always_comb begin
    asc = $signed({2'b00, mid_i.speed_quot}) - pgsc_pkg::DivOffset;
    if (asc > pgsc_pkg::AccelCap) begin
      asc = pgsc_pkg::AccelCap;
    end
    err16     = $signed({mid_i.gap[pgsc_pkg::GapW-1], mid_i.gap, 8'b0}) -
                $signed({1'b0, mid_i.spacing});
    err_round = err16 + 27'sd512;
    err_q8    = err_round[26:10];
    agap      = {{2{mid_i.rate[pgsc_pkg::RateW-1]}}, mid_i.rate} +
                {{11{err_q8[16]}}, err_q8};
    if (mid_i.gap_mode == pgsc_pkg::ModeSpeed) begin
      cmd = {{11{asc[16]}}, asc};
    end else if (agap > 28'sd512) begin
      cmd = 28'sd512;
    end else if (mid_i.platoon_role) begin
      cmd = agap;
    end else begin
      cmd = {{15{mid_i.driver_accel[pgsc_pkg::AccelInW-1]}}, mid_i.driver_accel};
    end
    if (cmd < -28'sd32768) begin
      accel_d = -16'sd32768;
    end else if (cmd > 28'sd32767) begin
      accel_d = 16'sd32767;
    end else begin
      accel_d = cmd[pgsc_pkg::AccelW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mid_ready_o) begin
      out_valid_q <= mid_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      accel_q     <= accel_d;
      mode_q      <= mid_i.gap_mode;
      colour_q    <= mid_i.colour;
      follow_q    <= mid_i.follow;
      gap_q       <= mid_i.gap;
      gap_valid_q <= mid_i.gap_valid;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.accel_command = accel_q;
  assign out_o.gap_mode      = mode_q;
  assign out_o.status_colour = colour_q;
  assign out_o.follow_ticks  = follow_q;
  assign out_o.bumper_gap    = gap_q;
  assign out_o.gap_valid     = gap_valid_q;

  a_speed_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (mode_q == pgsc_pkg::ModeSpeed) |-> accel_q <= 16'sd512)
    else $error("speed command above cap");

  a_gap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !gap_valid_q |-> (gap_q == '0) && (mode_q == pgsc_pkg::ModeSpeed))
    else $error("gap or mode set without a leader");

endmodule

// ===== hdl/platoon_gap_speed_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// platoon_gap_speed_controller_top
// Gap and speed controller for platoon driving, one command word per tick.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    tick measurement and own state
//   out_o    out  valid/ready    command, mode, colour, counter, gap
//   cfg_i    in   valid/ready    register index and write data
//
// three register stages (input, middle, result): an accepted word moves through
// them in that order, one word accepted per cycle sustained while the result is taken
// the tracking state updates as a word leaves the input register
// a stalled result holds all stages behind it, no word is dropped
// reset clears valids, tracking state and restores register defaults
// ----------------------------------------------------------------------------
module platoon_gap_speed_controller_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  pgsc_in_if.sink      in_i,
  pgsc_out_if.source   out_o,
  pgsc_cfg_if.sink     cfg_i
);

  pgsc_pkg::cfg_t cfg;
  pgsc_pkg::mid_t mid;
  logic           mid_valid;
  logic           mid_ready;

  pgsc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  pgsc_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_o       (mid)
  );

  pgsc_command u_command (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_i       (mid),
    .out_o       (out_o)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the platoon gap and speed controller: a queue-fed
// driver offers tick words in random bursts, a per-word model of the
// gap tracking, follow counter and mode hysteresis predicts each command
// word, and a monitor with its own stall pattern checks every field.
// ----------------------------------------------------------------------------
module testbench;
  import pgsc_pkg::*;

  localparam int PipeDepth  = 3;
  localparam logic [CfgIdxW-1:0] UnusedIdx = '1;
  localparam longint CmdMin = -(longint'(1) << (AccelW - 1));
  localparam longint CmdMax = (longint'(1) << (AccelW - 1)) - 1;

  typedef struct packed {
    logic                       has_leader;
    logic [IdW-1:0]             lead_vid;
    logic [DistW-1:0]           lead_range;
    logic [LenW-1:0]            lead_len;
    logic [SpeedW-1:0]          speed;
    logic [1:0]                 own_status;
    logic [2:0]                 lead_status;
    logic signed [AccelInW-1:0] drv_accel;
  } tick_t;

  typedef struct packed {
    logic signed [AccelW-1:0] accel;
    logic                     mode;
    logic [1:0]               colour;
    logic [CountW-1:0]        follow;
    logic signed [GapW-1:0]   gap;
    logic                     gap_ok;
  } cmd_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  pgsc_in_if  tick_if ();
  pgsc_out_if cmd_if ();
  pgsc_cfg_if reg_if ();

  platoon_gap_speed_controller_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (cmd_if),
    .cfg_i  (reg_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // register copies
  logic [SpeedW-1:0]   man_speed  = ManualSpeedRst;
  logic [SpeedW-1:0]   plat_speed = PlatoonSpeedRst;
  logic [TimeGapW-1:0] plat_gap   = PlatoonGapRst;
  logic [TimeGapW-1:0] drv_gap    = DriverGapRst;
  logic [TicksW-1:0]   tick_rate  = TicksRst;

  // tracking state
  longint        gap_cur     = 0;
  logic          gap_cur_ok  = 1'b0;
  longint        gap_prev    = 0;
  logic          gap_prev_ok = 1'b0;
  logic          mode_now    = ModeSpeed;
  logic [IdW:0]  last_lead   = '0;
  logic [CountW-1:0] follow_cnt = '0;

  tick_t     tick_q[$];
  cmd_word_t cmd_q[$];
  tick_t     offered;

  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  int next_hold_at = 100;
  int style = 0;
  int style_left = 0;
  int results_seen = 0;
  int fail_count = 0;

  int trip_left = 0;
  int trip_dist = 0;
  logic [IdW-1:0] trip_id = '0;
  logic [LenW-1:0] trip_len = '0;

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic cmd_word_t control_step(tick_t t);
    cmd_word_t w;
    logic platoon;
    logic [IdW:0] lead_tag;
    longint speed, target, speed_cmd, tgap, spacing, err, rate, gap_cmd, cmd;
    platoon = (t.own_status == StatusFollower) || (t.own_status == StatusMember);

    gap_prev = gap_cur;
    gap_prev_ok = gap_cur_ok;
    if (t.has_leader) begin
      gap_cur = longint'(t.lead_range) - longint'(t.lead_len);
      gap_cur_ok = 1'b1;
    end else begin
      gap_cur = 0;
      gap_cur_ok = 1'b0;
    end

    lead_tag = t.has_leader ? {1'b1, t.lead_vid} : '0;
    if (t.has_leader && lead_tag == last_lead && gap_cur < longint'(GapNear) &&
        t.lead_status <= LeaderKnownMax) begin
      if (follow_cnt != CountMax) follow_cnt = follow_cnt + 1'b1;
    end else begin
      follow_cnt = '0;
    end
    last_lead = lead_tag;

    speed = longint'(t.speed);
    target = platoon ? longint'(plat_speed) : longint'(man_speed);
    speed_cmd = floor_quot(-4 * (speed - target) + 5, 10);
    if (speed_cmd > longint'(AccelCap)) speed_cmd = longint'(AccelCap);

    // hysteresis between the far and near thresholds
    if (!t.has_leader || gap_cur > longint'(GapFar)) mode_now = ModeSpeed;
    if (gap_cur_ok && gap_prev_ok && gap_cur < longint'(GapNear)) mode_now = ModeGap;

    if (mode_now == ModeSpeed) begin
      cmd = speed_cmd;
    end else begin
      tgap = platoon ? longint'(plat_gap) : longint'(drv_gap);
      spacing = tgap * speed;
      if (speed <= longint'(LowSpeed)) spacing = spacing + longint'(SlowMargin);
      err = gap_cur * 256 - spacing;
      rate = (gap_cur - gap_prev) * longint'(tick_rate);
      gap_cmd = rate + floor_quot(err + 512, 1024);
      if (gap_cmd > longint'(AccelCap)) cmd = longint'(AccelCap);
      else if (platoon) cmd = gap_cmd;
      else cmd = longint'(t.drv_accel);
    end
    if (cmd < CmdMin) cmd = CmdMin;
    if (cmd > CmdMax) cmd = CmdMax;

    w.accel = cmd[AccelW-1:0];
    w.mode = mode_now;
    if (t.own_status == StatusLeader) w.colour = ColourRed;
    else if (platoon) w.colour = ColourYellow;
    else w.colour = ColourBlue;
    w.follow = follow_cnt;
    w.gap = gap_cur[GapW-1:0];
    w.gap_ok = gap_cur_ok;
    return w;
  endfunction

  function automatic void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    case (idx)
      CfgManualSpeed:  man_speed  = value[SpeedW-1:0];
      CfgPlatoonSpeed: plat_speed = value[SpeedW-1:0];
      CfgPlatoonGap:   plat_gap   = value[TimeGapW-1:0];
      CfgDriverGap:    drv_gap    = value[TimeGapW-1:0];
      CfgTicks:        tick_rate  = value[TicksW-1:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
      {tick_if.has_leader, tick_if.lead_vid, tick_if.lead_distance, tick_if.lead_length,
       tick_if.own_speed, tick_if.own_status, tick_if.leader_status,
       tick_if.driver_accel} <= '0;
    end else begin
      if (tick_if.valid && tick_if.ready) cmd_q.push_back(control_step(offered));
      if (!tick_if.valid || tick_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          tick_if.valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          offered = tick_q.pop_front();
          tick_if.valid <= 1'b1;
          {tick_if.has_leader, tick_if.lead_vid, tick_if.lead_distance, tick_if.lead_length,
           tick_if.own_speed, tick_if.own_status, tick_if.leader_status,
           tick_if.driver_accel} <= offered;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_word_t want;
    if (!rst_ni) begin
      cmd_if.ready <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        results_seen++;
        if (cmd_q.size() == 0) begin
          fail_count++;
          $error("command word with none expected");
        end else begin
          want = cmd_q.pop_front();
          check_field("accel_command", want.accel, cmd_if.accel_command);
          check_field("gap_mode", want.mode, cmd_if.gap_mode);
          check_field("status_colour", want.colour, cmd_if.status_colour);
          check_field("follow_ticks", want.follow, cmd_if.follow_ticks);
          check_field("bumper_gap", want.gap, cmd_if.bumper_gap);
          check_field("gap_valid", want.gap_ok, cmd_if.gap_valid);
        end
      end
      // long hold-off so the pipeline fills and backs up the input
      if (hold_left == 0 && holds_done < 3 && tick_q.size() > 60 &&
          results_seen >= next_hold_at) begin
        hold_left = 90;
        holds_done++;
        next_hold_at = results_seen + 250;
      end
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 120);
      end else begin
        style_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        cmd_if.ready <= 1'b0;
      end else begin
        case (style)
          0: cmd_if.ready <= 1'b1;
          1: cmd_if.ready <= 1'($urandom_range(0, 1));
          2: cmd_if.ready <= ($urandom_range(0, 3) == 0);
          default: cmd_if.ready <= !cmd_if.ready;
        endcase
      end
    end
  end

  task automatic add_tick(logic has, logic [IdW-1:0] id, logic [DistW-1:0] rng,
                          logic [LenW-1:0] len, logic [SpeedW-1:0] speed,
                          logic [1:0] own, logic [2:0] lstat,
                          logic signed [AccelInW-1:0] acc);
    tick_t t;
    t = '{has, id, rng, len, speed, own, lstat, acc};
    tick_q.push_back(t);
  endtask

  // mostly coherent approach episodes with one leader, plus raw noise words
  task automatic queue_random(int count);
    tick_t t;
    int a;
    for (int n = 0; n < count; n++) begin
      if (trip_left == 0) begin
        trip_left = $urandom_range(4, 40);
        trip_id = 16'($urandom);
        trip_dist = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
                                                : $urandom_range(0, 36000);
        trip_len = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(300, 1500));
      end
      trip_left--;
      if ($urandom_range(0, 99) < 12) begin
        t = tick_t'({$urandom, $urandom, $urandom});
      end else begin
        trip_dist = trip_dist + int'($urandom_range(0, 1200)) - 600;
        if (trip_dist < 0) trip_dist = 0;
        if (trip_dist > 131071) trip_dist = 131071;
        t.has_leader = ($urandom_range(0, 19) != 0);
        t.lead_vid = ($urandom_range(0, 29) == 0) ? 16'($urandom) : trip_id;
        t.lead_range = trip_dist[DistW-1:0];
        t.lead_len = trip_len;
        t.speed = 14'($urandom);
        t.own_status = 2'($urandom);
        t.lead_status = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                                   : 3'($urandom_range(0, 3));
        a = int'($urandom_range(0, 5120)) - 2560;
        t.drv_accel = ($urandom_range(0, 15) == 0) ? 13'($urandom) : a[AccelInW-1:0];
      end
      tick_q.push_back(t);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= value;
    do @(posedge clk_i); while (!reg_if.ready);
    set_reg(idx, value);
    reg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (tick_q.size() != 0 || cmd_q.size() != 0 || tick_if.valid) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  initial begin
    reg_if.valid <= 1'b0;
    reg_if.index <= CfgManualSpeed;
    reg_if.data  <= '0;
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed words at reset register values
    add_tick(1'b0, '0, '0, '0, '0, StatusOff, 3'd0, -13'sd2560);
    add_tick(1'b1, '1, '1, '0, '1, StatusLeader, 3'd0, 13'sd2560);
    add_tick(1'b1, '1, 17'd20000, 13'd1000, LowSpeed, StatusFollower, 3'd1, 13'sd0);
    add_tick(1'b1, '1, 17'd19000, 13'd1000, LowSpeed + 1'b1, StatusMember, 3'd2, 13'sd100);
    add_tick(1'b1, '1, 17'd26600, 13'd1000, 14'd3000, StatusFollower, 3'd3, 13'sd0);
    add_tick(1'b1, '1, 17'd28000, 13'd0, 14'd5000, StatusOff, 3'd0, -13'sd300);
    add_tick(1'b1, '1, 17'd30720, 13'd0, 14'd5000, StatusLeader, 3'd0, 13'sd200);
    add_tick(1'b1, '1, 17'd30721, 13'd0, 14'd9000, StatusMember, 3'd0, 13'sd0);
    add_tick(1'b1, '1, 17'd29000, 13'd0, 14'd9000, StatusFollower, 3'd0, 13'sd0);
    add_tick(1'b1, '1, 17'd25599, 13'd0, 14'd7000, StatusFollower, 3'd2, 13'sd0);
    add_tick(1'b1, '1, 17'd20000, 13'd0, 14'd7000, StatusFollower, 3'd4, 13'sd0);
    add_tick(1'b1, '1, 17'd20000, 13'd0, 14'd7000, StatusMember, 3'd7, 13'sd0);
    add_tick(1'b1, '0, 17'd20000, 13'd0, 14'd7000, StatusMember, 3'd1, 13'sd0);
    add_tick(1'b1, '0, 17'd20000, 13'd0, 14'd7000, StatusMember, 3'd1, 13'sd0);
    add_tick(1'b1, '0, '0, '1, 14'd8000, StatusFollower, 3'd0, 13'sd0);
    add_tick(1'b1, '0, '1, '0, 14'd8000, StatusFollower, 3'd0, 13'sd0);
    add_tick(1'b0, '0, '0, '0, '1, StatusMember, 3'd0, 13'sd0);
    add_tick(1'b1, 16'h5A5A, 17'd24000, 13'd0, '0, StatusOff, 3'd0, 13'h1000);
    add_tick(1'b1, 16'h5A5A, 17'd24000, 13'd0, '0, StatusOff, 3'd0, 13'h0FFF);
    add_tick(1'b1, 16'h5A5A, 17'd24000, 13'd0, '1, StatusOff, 3'd0, 13'h0FFF);
    add_tick(1'b1, 16'h5A5A, 17'd24000, 13'd0, '1, StatusLeader, 3'd0, '1);
    add_tick(1'b1, 16'h5A5A, 17'd23000, 13'd200, 14'd100, StatusMember, 3'd3, 13'sd0);
    wait_idle();

    write_reg(CfgManualSpeed, 14'($urandom));
    write_reg(CfgPlatoonSpeed, 14'($urandom));
    write_reg(CfgPlatoonGap, 14'($urandom_range(0, 1280)));
    write_reg(CfgDriverGap, 14'($urandom_range(0, 1280)));
    write_reg(CfgTicks, 14'($urandom_range(1, 100)));
    queue_random(200);
    wait_idle();

    // low extremes, zero tick rate kills the gap rate term
    write_reg(CfgManualSpeed, '0);
    write_reg(CfgPlatoonSpeed, '0);
    write_reg(CfgPlatoonGap, '0);
    write_reg(CfgDriverGap, '0);
    write_reg(CfgTicks, '0);
    write_reg(UnusedIdx, '1);
    queue_random(150);
    wait_idle();

    write_reg(CfgManualSpeed, '1);
    write_reg(CfgPlatoonSpeed, '1);
    write_reg(CfgPlatoonGap, 14'd1280);
    write_reg(CfgDriverGap, 14'd1280);
    write_reg(CfgTicks, 14'd100);
    queue_random(150);
    wait_idle();

    // full width writes, upper bits are dropped by narrow registers
    write_reg(CfgManualSpeed, 14'($urandom));
    write_reg(CfgPlatoonSpeed, 14'($urandom));
    write_reg(CfgPlatoonGap, 14'($urandom));
    write_reg(CfgDriverGap, 14'($urandom));
    write_reg(CfgTicks, 14'($urandom));
    queue_random(150);
    wait_idle();

    write_reg(CfgManualSpeed, ManualSpeedRst);
    write_reg(CfgPlatoonSpeed, PlatoonSpeedRst);
    write_reg(CfgPlatoonGap, CfgDataW'(PlatoonGapRst));
    write_reg(CfgDriverGap, CfgDataW'(DriverGapRst));
    write_reg(CfgTicks, 14'd1);
    queue_random(200);
    wait_idle();

    queue_random(20);
    wait_idle();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== platoon_gap_speed_controller_top.f =====
hdl/pgsc_pkg.sv
hdl/pgsc_if.sv
hdl/pgsc_cfg_regs.sv
hdl/pgsc_track.sv
hdl/pgsc_command.sv
hdl/platoon_gap_speed_controller_top.sv
tb/sv/testbench.sv
